// ===== design/psh_pkg.sv =====
// ----------------------------------------------------------------------------
// psh_pkg
// Shared widths, register indexes, reset values and types of the program
// address sample histogram.
// ----------------------------------------------------------------------------
package psh_pkg;

   localparam int ADDR_WIDTH      = 32;
   localparam int SCALE_WIDTH     = 17;
   localparam int COUNT_WIDTH     = 13;
   localparam int INDEX_WIDTH     = 16;
   localparam int VALUE_WIDTH     = 16;
   localparam int FRAC_BITS       = 16;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int MAX_BINS_DEFAULT = 4096;

   localparam logic [ADDR_WIDTH-1:0]  BASE_OFFSET_RESET  = '0;
   localparam logic [SCALE_WIDTH-1:0] SCALE_FACTOR_RESET = 17'd65536;
   localparam logic [COUNT_WIDTH-1:0] BIN_COUNT_RESET    = 13'd4096;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BASE_OFFSET  = 2'd0,
      CSR_SCALE_FACTOR = 2'd1,
      CSR_BIN_COUNT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]  base_offset;
      logic [SCALE_WIDTH-1:0] scale_factor;
      logic [COUNT_WIDTH-1:0] bin_count;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      logic                   hit;
      logic [INDEX_WIDTH-1:0] bin_index;
   } bin_req_type;

endpackage

// ===== design/psh_ram.sv =====
// ----------------------------------------------------------------------------
// psh_ram
// Generic single write port, single read port memory with a registered read.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module psh_ram #(
   parameter int WIDTH = psh_pkg::VALUE_WIDTH,
   parameter int DEPTH = psh_pkg::MAX_BINS_DEFAULT,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/psh_index.sv =====
// ----------------------------------------------------------------------------
// psh_index
// Input register and bin index stage. The sample is offset, scaled by the
// 1.16 factor and checked against the bin limits.
// ----------------------------------------------------------------------------
module psh_index #(
   parameter int MAX_BINS = psh_pkg::MAX_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clearing,
   input  psh_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [psh_pkg::ADDR_WIDTH-1:0]      req_sampled_address,
   output psh_pkg::bin_req_type                bin_req,
   input  logic                                take
);

   import psh_pkg::*;

   localparam int ProdWidth = ADDR_WIDTH + SCALE_WIDTH;
   localparam logic [INDEX_WIDTH:0] BinLimit = (INDEX_WIDTH + 1)'(MAX_BINS);

   logic                  s1_vld_ff, s1_vld_in;
   logic [ADDR_WIDTH-1:0] s1_addr_ff;
   bin_req_type           s2_ff, s2_in;
   logic                  s1_en, s2_en;
   logic [ADDR_WIDTH-1:0] offset;
   logic [ProdWidth-1:0]  product;
   logic [INDEX_WIDTH-1:0] index;

   assign s2_en     = !s2_ff.valid || take;
   assign s1_en     = !s1_vld_ff || s2_en;
   assign req_ready = s1_en && !clearing;

   always_comb begin
      offset  = s1_addr_ff - cfg.base_offset;
      product = {{SCALE_WIDTH{1'b0}}, offset} * {{ADDR_WIDTH{1'b0}}, cfg.scale_factor};
      index   = product[FRAC_BITS +: INDEX_WIDTH];
      s1_vld_in       = req_valid && req_ready;
      s2_in.valid     = s1_vld_ff;
      s2_in.bin_index = index;
      s2_in.hit       = (index < {{(INDEX_WIDTH - COUNT_WIDTH){1'b0}}, cfg.bin_count})
                        && ({1'b0, index} < BinLimit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_ff.valid  <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_vld_ff <= s1_vld_in;
         end
         if (s2_en) begin
            s2_ff.valid <= s2_in.valid;
         end
      end
      if (req_valid && req_ready) begin
         s1_addr_ff <= req_sampled_address;
      end
      if (s2_en) begin
         s2_ff.hit       <= s2_in.hit;
         s2_ff.bin_index <= s2_in.bin_index;
      end
   end

   assign bin_req = s2_ff;

endmodule

// ===== design/psh_count.sv =====
// ----------------------------------------------------------------------------
// psh_count
// Bin counter update and result register. Reads the bin, adds one with
// forwarding of the most recent write, writes it back and presents the word.
// ----------------------------------------------------------------------------
module psh_count #(
   parameter int MAX_BINS = psh_pkg::MAX_BINS_DEFAULT,
   localparam int AddrWidth = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  psh_pkg::bin_req_type                bin_req,
   output logic                                take,
   output logic                                rd_en,
   output logic [AddrWidth-1:0]                rd_addr,
   input  logic [psh_pkg::VALUE_WIDTH-1:0]     rd_data,
   output logic                                wr_en,
   output logic [AddrWidth-1:0]                wr_addr,
   output logic [psh_pkg::VALUE_WIDTH-1:0]     wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_in_range,
   output logic [psh_pkg::INDEX_WIDTH-1:0]     rsp_bin_index,
   output logic [psh_pkg::VALUE_WIDTH-1:0]     rsp_bin_value
);

   import psh_pkg::*;

   bin_req_type            s3_ff;
   logic                   fwd_vld_ff;
   logic [AddrWidth-1:0]   fwd_addr_ff;
   logic [VALUE_WIDTH-1:0] fwd_val_ff;
   logic                   rsp_vld_ff;
   logic                   rsp_in_range_ff;
   logic [INDEX_WIDTH-1:0] rsp_bin_index_ff;
   logic [VALUE_WIDTH-1:0] rsp_bin_value_ff;
   logic                   out_en, s3_en, retire;
   logic [AddrWidth-1:0]   s3_addr;
   logic [VALUE_WIDTH-1:0] count_cur, count_in;

   assign out_en  = !rsp_vld_ff || rsp_ready;
   assign s3_en   = !s3_ff.valid || out_en;
   assign take    = s3_en;
   assign retire  = out_en && s3_ff.valid;
   assign rd_en   = s3_en && bin_req.valid;
   assign rd_addr = bin_req.bin_index[AddrWidth-1:0];
   assign s3_addr = s3_ff.bin_index[AddrWidth-1:0];

   // The memory returns the old contents when read and written together,
   // so the last written count takes over when it belongs to this bin.
   always_comb begin
      count_cur = (fwd_vld_ff && (fwd_addr_ff == s3_addr)) ? fwd_val_ff : rd_data;
      count_in  = count_cur + VALUE_WIDTH'(1);
   end

   assign wr_en   = retire && s3_ff.hit;
   assign wr_addr = s3_addr;
   assign wr_data = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
         fwd_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (s3_en) begin
            s3_ff.valid <= bin_req.valid;
         end
         if (wr_en) begin
            fwd_vld_ff <= 1'b1;
         end
         if (out_en) begin
            rsp_vld_ff <= s3_ff.valid;
         end
      end
      if (s3_en) begin
         s3_ff.hit       <= bin_req.hit;
         s3_ff.bin_index <= bin_req.bin_index;
      end
      if (wr_en) begin
         fwd_addr_ff <= s3_addr;
         fwd_val_ff  <= count_in;
      end
      if (retire) begin
         rsp_in_range_ff  <= s3_ff.hit;
         rsp_bin_index_ff <= s3_ff.bin_index;
         rsp_bin_value_ff <= s3_ff.hit ? count_in : '0;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_in_range  = rsp_in_range_ff;
   assign rsp_bin_index = rsp_bin_index_ff;
   assign rsp_bin_value = rsp_bin_value_ff;

endmodule

// ===== design/pc_sample_histogram.sv =====
// ----------------------------------------------------------------------------
// pc_sample_histogram
// Profiling histogram of sampled program addresses with 16-bit bin counters.
// ----------------------------------------------------------------------------
// Pipeline: a sample goes through the input, index, count and result registers.
// Throughput: one sample per cycle while results are taken; repeated bins are
// forwarded, no stall. Reset: configuration returns to defaults and a clearing
// pass zeroes the bin memory, one bin per cycle, while req_ready is low.
// Configuration writes are taken during the clearing pass.
module pc_sample_histogram #(
   parameter int MAX_BINS = psh_pkg::MAX_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [psh_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [psh_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [psh_pkg::ADDR_WIDTH-1:0]      req_sampled_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_in_range,
   output logic [psh_pkg::INDEX_WIDTH-1:0]     rsp_bin_index,
   output logic [psh_pkg::VALUE_WIDTH-1:0]     rsp_bin_value
);

   import psh_pkg::*;

   localparam int AddrWidth = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam logic [AddrWidth-1:0] LastBin = AddrWidth'(MAX_BINS - 1);

   cfg_type                cfg_ff;
   logic                   clr_busy_ff;
   logic [AddrWidth-1:0]   clr_addr_ff;
   bin_req_type            bin_req;
   logic                   take;
   logic                   rd_en;
   logic [AddrWidth-1:0]   rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                   cnt_wr_en;
   logic [AddrWidth-1:0]   cnt_wr_addr;
   logic [VALUE_WIDTH-1:0] cnt_wr_data;
   logic                   ram_wr_en;
   logic [AddrWidth-1:0]   ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_offset  <= BASE_OFFSET_RESET;
         cfg_ff.scale_factor <= SCALE_FACTOR_RESET;
         cfg_ff.bin_count    <= BIN_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE_OFFSET: begin
               cfg_ff.base_offset <= csr_write_data[ADDR_WIDTH-1:0];
            end
            CSR_SCALE_FACTOR: begin
               cfg_ff.scale_factor <= csr_write_data[SCALE_WIDTH-1:0];
            end
            CSR_BIN_COUNT: begin
               cfg_ff.bin_count <= csr_write_data[COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AddrWidth'(1);
         if (clr_addr_ff == LastBin) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign ram_wr_en   = clr_busy_ff || cnt_wr_en;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : cnt_wr_addr;
   assign ram_wr_data = clr_busy_ff ? '0 : cnt_wr_data;

   psh_index #(
      .MAX_BINS (MAX_BINS)
   ) u_index (
      .clock               (clock),
      .reset               (reset),
      .clearing            (clr_busy_ff),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sampled_address (req_sampled_address),
      .bin_req             (bin_req),
      .take                (take)
   );

   psh_count #(
      .MAX_BINS (MAX_BINS)
   ) u_count (
      .clock         (clock),
      .reset         (reset),
      .bin_req       (bin_req),
      .take          (take),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .wr_en         (cnt_wr_en),
      .wr_addr       (cnt_wr_addr),
      .wr_data       (cnt_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_in_range  (rsp_in_range),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_value (rsp_bin_value)
   );

   psh_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the program address sample histogram. Sample words
// go in on the request channel and result words are checked against a bin
// predictor in a scoreboard class. Register settings change between drained
// phases. Random gaps are applied on both channels, with one long result-side
// hold.
// ----------------------------------------------------------------------------
module tb_top;
   import psh_pkg::*;

   localparam int RESULT_LATENCY   = 3;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES    = 7;
   localparam int PHASE_SAMPLES    = 150;
   localparam int REPORT_LIMIT     = 10;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                   in_range;
      logic [INDEX_WIDTH-1:0] bin_index;
      logic [VALUE_WIDTH-1:0] bin_value;
   } bin_result_type;

   class histogram_scoreboard;
      logic [ADDR_WIDTH-1:0]  base_offset;
      logic [SCALE_WIDTH-1:0] scale_factor;
      logic [COUNT_WIDTH-1:0] bin_count;
      logic [VALUE_WIDTH-1:0] bin_counts [MAX_BINS_DEFAULT];
      bin_result_type         expected_bins [$];
      int unsigned            mismatch_count;
      int unsigned            checked_count;
      int unsigned            hit_count;
      int unsigned            wrap_count;

      function new();
         base_offset    = BASE_OFFSET_RESET;
         scale_factor   = SCALE_FACTOR_RESET;
         bin_count      = BIN_COUNT_RESET;
         mismatch_count = 0;
         checked_count  = 0;
         hit_count      = 0;
         wrap_count     = 0;
         foreach (bin_counts[i]) bin_counts[i] = '0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_BASE_OFFSET:  base_offset  = data[ADDR_WIDTH-1:0];
            CSR_SCALE_FACTOR: scale_factor = data[SCALE_WIDTH-1:0];
            CSR_BIN_COUNT:    bin_count    = data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void count_sample(logic [ADDR_WIDTH-1:0] address);
         logic [ADDR_WIDTH-1:0] offset;
         logic [63:0]           product;
         bin_result_type        bin_result;
         offset = address - base_offset;
         product = {32'b0, offset} * {47'b0, scale_factor};
         bin_result.bin_index = product[FRAC_BITS +: INDEX_WIDTH];
         bin_result.in_range  = (bin_result.bin_index < bin_count) &&
                                (bin_result.bin_index < MAX_BINS_DEFAULT);
         bin_result.bin_value = '0;
         if (bin_result.in_range) begin
            bin_counts[bin_result.bin_index] = bin_counts[bin_result.bin_index] + 1'b1;
            bin_result.bin_value = bin_counts[bin_result.bin_index];
         end
         expected_bins.push_back(bin_result);
      endfunction

      function void note_mismatch(string text);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", text);
      endfunction

      function void compare_result(logic in_range, logic [INDEX_WIDTH-1:0] bin_index,
                                   logic [VALUE_WIDTH-1:0] bin_value);
         bin_result_type wanted;
         if (expected_bins.size() == 0) begin
            note_mismatch($sformatf("unexpected word: in_range %0b index %0d value %0d",
                                    in_range, bin_index, bin_value));
            return;
         end
         wanted = expected_bins.pop_front();
         checked_count++;
         if (in_range !== wanted.in_range || bin_index !== wanted.bin_index ||
             bin_value !== wanted.bin_value) begin
            note_mismatch($sformatf(
               "word %0d: expected in_range %0b index %0d value %0d, got %0b %0d %0d",
               checked_count, wanted.in_range, wanted.bin_index, wanted.bin_value,
               in_range, bin_index, bin_value));
         end else if (wanted.in_range) begin
            hit_count++;
            if (wanted.bin_value == '0) wrap_count++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;
   logic                       req_valid;
   logic                       req_ready;
   logic [ADDR_WIDTH-1:0]      req_sampled_address;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_in_range;
   logic [INDEX_WIDTH-1:0]     rsp_bin_index;
   logic [VALUE_WIDTH-1:0]     rsp_bin_value;

   histogram_scoreboard   board;
   bit                    idle_on;
   bit                    hold_request;
   int unsigned           cycle_count = 0;
   int unsigned           sample_count = 0;
   int unsigned           setting_count = 0;
   int unsigned           near_span;
   logic [ADDR_WIDTH-1:0] near_base;
   logic [ADDR_WIDTH-1:0] last_address;

   pc_sample_histogram #(
      .MAX_BINS(MAX_BINS_DEFAULT)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sampled_address (req_sampled_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_in_range        (rsp_in_range),
      .rsp_bin_index       (rsp_bin_index),
      .rsp_bin_value       (rsp_bin_value)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding.",
                  cycle_count, board.expected_bins.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.compare_result(rsp_in_range, rsp_bin_index, rsp_bin_value);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] random_address();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return $urandom();
      if (roll < 35) return last_address;
      return near_base + $urandom_range(0, near_span - 1);
   endfunction

   initial begin : result_side
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            stall_left = LONG_HOLD_CYCLES - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on) stall_left = pick_gap();
         end
      end
   end

   task automatic send_sample(input logic [ADDR_WIDTH-1:0] address);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sampled_address <= address;
      do @(posedge clock); while (!req_ready);
      board.count_sample(address);
      sample_count++;
      last_address = address;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_bins.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_register(index, data);
      setting_count++;
   endtask

   initial begin : stimulus
      board = new();
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_BASE_OFFSET;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_sampled_address = '0;
      idle_on = 1'b0;
      hold_request = 1'b0;
      near_base = '0;
      near_span = 16;
      last_address = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_sample(32'h0000_0000);
      send_sample(32'h0000_0000);
      send_sample(32'h0000_0FFF);
      send_sample(32'h0000_1000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h5555_AAAA);
      send_sample(32'hAAAA_0555);
      wait_for_results();

      write_register(CSR_BASE_OFFSET, 32'hFFFF_FFFF);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFE);
      wait_for_results();

      write_register(CSR_BASE_OFFSET, 32'h0000_0000);
      write_register(CSR_SCALE_FACTOR, 32'hFFFF_FFFF);
      write_register(CSR_BIN_COUNT, 32'hFFFF_FFFF);
      send_sample(32'h0000_8000);
      send_sample(32'h0000_0001);
      send_sample(32'h0000_0800);
      wait_for_results();

      write_register(CSR_SCALE_FACTOR, 32'h0001_0000);
      write_register(CSR_BIN_COUNT, 32'hFFFF_E000);
      write_register(CSR_UNUSED, $urandom());
      send_sample(32'h0000_0000);
      send_sample(32'h0000_0001);
      send_sample($urandom());
      wait_for_results();

      write_register(CSR_BIN_COUNT, 32'h0000_0001);
      write_register(CSR_SCALE_FACTOR, 32'h0002_0000);
      send_sample($urandom());
      send_sample($urandom());
      wait_for_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase % 3) != 0;
         near_base = $urandom();
         near_span = 1 << $urandom_range(2, 20);
         write_register(CSR_BASE_OFFSET, near_base);
         case ($urandom_range(0, 3))
            0:       write_register(CSR_SCALE_FACTOR, 32'h0001_0000);
            1:       write_register(CSR_SCALE_FACTOR, $urandom_range(1, 256));
            2:       write_register(CSR_SCALE_FACTOR, $urandom_range(0, 32'h1_FFFF));
            default: write_register(CSR_SCALE_FACTOR, $urandom_range(4096, 65536));
         endcase
         case ($urandom_range(0, 3))
            0:       write_register(CSR_BIN_COUNT, MAX_BINS_DEFAULT);
            1:       write_register(CSR_BIN_COUNT, $urandom_range(1, 64));
            2:       write_register(CSR_BIN_COUNT, $urandom_range(0, 8191));
            default: write_register(CSR_BIN_COUNT, $urandom_range(4000, 4096));
         endcase
         if (phase == 3) hold_request = 1'b1;
         repeat (PHASE_SAMPLES) send_sample(random_address());
         wait_for_results();
      end

      repeat (4 * RESULT_LATENCY) @(posedge clock);
      $display("Run covered %0d sample words and %0d register writes, with a %0d-cycle hold.",
               sample_count, setting_count, LONG_HOLD_CYCLES);
      $display("Checked %0d result words: %0d in range, %0d counter wraps, %0d mismatches.",
               board.checked_count, board.hit_count, board.wrap_count, board.mismatch_count);
      if (board.mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
